// ----- design/press_contact_sequencer_assert.svh -----
// ----------------------------------------------------------------------------
// press_contact_sequencer_assert.svh
// Assertion macros for the press contact sequencer. They assume a clock
// named clk and an active-low synchronous reset named rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef PRESS_CONTACT_SEQUENCER_ASSERT_SVH
`define PRESS_CONTACT_SEQUENCER_ASSERT_SVH

// Same-cycle implication, off during reset
`define PCS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset
`define PCS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/pcs_pkg.sv -----
// ----------------------------------------------------------------------------
// pcs_pkg
// Types and codes shared by the press contact sequencer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pcs_pkg;

  // Stroke phases
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_BASE  = 3'd1,
    PH_DESC  = 3'd2,
    PH_PRESS = 3'd3,
    PH_RETR  = 3'd4,
    PH_DONE  = 3'd5
  } phase_t;

  // Reported events
  typedef enum logic [3:0] {
    EV_NONE          = 4'd0,
    EV_ACTIVE        = 4'd1,
    EV_OTHER_BUSY    = 4'd2,
    EV_LASER_NRDY    = 4'd3,
    EV_NO_TRAVEL     = 4'd4,
    EV_BASE_FAIL     = 4'd5,
    EV_DESC_START    = 4'd6,
    EV_CONTACT       = 4'd7,
    EV_DESC_LIMIT    = 4'd8,
    EV_FORCE_LIMIT   = 4'd9,
    EV_DEPTH_LIMIT   = 4'd10,
    EV_TRAVEL_LIMIT  = 4'd11,
    EV_RETRACTED     = 4'd12,
    EV_DONE_OK       = 4'd13,
    EV_DONE_FAIL     = 4'd14
  } event_t;

  // Motor commands
  typedef enum logic [1:0] {
    CMD_NONE    = 2'd0,
    CMD_STOP    = 2'd1,
    CMD_DOWN    = 2'd2,
    CMD_RETRACT = 2'd3
  } motor_cmd_t;

  // Input item kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 23;
  localparam logic [CFG_IDX_W-1:0] REG_CONTACT_DROP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_COUNT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FORCE       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DEPTH       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_TARGET     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_TOLERANCE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_STABLE     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_TIMEOUT    = 3'd7;

  // Configuration register set
  typedef struct packed {
    logic [19:0] contact_drop_um;
    logic [7:0]  contact_confirm_count;
    logic [14:0] max_force_mn;
    logic [22:0] max_depth_um;
    logic [19:0] baseline_target_um;
    logic [19:0] baseline_tolerance_um;
    logic [7:0]  baseline_stable_count;
    logic [15:0] baseline_timeout_ticks;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    contact_drop_um:        20'd500,
    contact_confirm_count:  8'd3,
    max_force_mn:           15'd10000,
    max_depth_um:           23'd5000,
    baseline_target_um:     20'd100000,
    baseline_tolerance_um:  20'd5000,
    baseline_stable_count:  8'd5,
    baseline_timeout_ticks: 16'd100
  };

  // One result item
  typedef struct packed {
    phase_t             phase;
    event_t             event_res;
    motor_cmd_t         motor_cmd;
    logic [23:0]        move_steps;
    logic signed [23:0] depth_um;
    logic signed [23:0] surface_moved_um;
    logic               succeeded;
  } res_t;

endpackage

// ----- design/pcs_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// pcs_cfg_regs
// Configuration register file, written by index, with reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcs_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [pcs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pcs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output pcs_pkg::cfg_t                     cfg
);

  pcs_pkg::cfg_t cfg_r;
  pcs_pkg::cfg_t cfg_nxt;

  // Register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        pcs_pkg::REG_CONTACT_DROP:   cfg_nxt.contact_drop_um        = cfg_wdata[19:0];
        pcs_pkg::REG_CONFIRM_COUNT:  cfg_nxt.contact_confirm_count  = cfg_wdata[7:0];
        pcs_pkg::REG_MAX_FORCE:      cfg_nxt.max_force_mn           = cfg_wdata[14:0];
        pcs_pkg::REG_MAX_DEPTH:      cfg_nxt.max_depth_um           = cfg_wdata[22:0];
        pcs_pkg::REG_BASE_TARGET:    cfg_nxt.baseline_target_um     = cfg_wdata[19:0];
        pcs_pkg::REG_BASE_TOLERANCE: cfg_nxt.baseline_tolerance_um  = cfg_wdata[19:0];
        pcs_pkg::REG_BASE_STABLE:    cfg_nxt.baseline_stable_count  = cfg_wdata[7:0];
        pcs_pkg::REG_BASE_TIMEOUT:   cfg_nxt.baseline_timeout_ticks = cfg_wdata[15:0];
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= pcs_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- design/pcs_core.sv -----
// ----------------------------------------------------------------------------
// pcs_core
// Stroke state registers and the single-pass step logic for one item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcs_core #(
  parameter int unsigned LASER_BITS = 20
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step_en,
  input  pcs_pkg::cfg_t           cfg,
  input  logic                    kind,
  input  logic                    other_busy,
  input  logic                    laser_ready,
  input  logic [23:0]             down_travel_steps,
  input  logic [LASER_BITS-1:0]   laser_um,
  input  logic signed [15:0]      force_mn,
  input  logic signed [23:0]      z_down_um,
  input  logic                    motor_idle,
  input  logic                    homing_active,
  output pcs_pkg::res_t           res
);

  // Width for laser differences, and for surface movement
  localparam int unsigned DW = ((LASER_BITS > 20) ? LASER_BITS : 20) + 2;
  localparam int unsigned SW = ((DW > 25) ? DW : 25) + 1;

  // Stroke state
  pcs_pkg::phase_t         phase_r, phase_nxt;
  logic [7:0]              stable_run_r, stable_run_nxt;
  logic [15:0]             elapsed_r, elapsed_nxt;
  logic [23:0]             pending_r, pending_nxt;
  logic [LASER_BITS-1:0]   probe_r, probe_nxt;
  logic [7:0]              confirm_r, confirm_nxt;
  logic [LASER_BITS-1:0]   claser_r, claser_nxt;
  logic [23:0]             cz_r, cz_nxt;
  logic [23:0]             fdepth_r, fdepth_nxt;
  logic                    succ_r, succ_nxt;

  // Datapath
  logic signed [DW-1:0]    laser_s, target_s, tol_s, drop_cfg_s, probe_s, claser_s;
  logic signed [DW-1:0]    dev, abs_dev, desc_drop, press_drop;
  logic signed [24:0]      depth;
  logic signed [SW-1:0]    surf;
  logic signed [23:0]      depth_sat, surf_sat;
  logic                    in_tol, contact_hit, f_lim, d_lim;
  logic [7:0]              stable_inc, confirm_inc, stable_val;
  logic [15:0]             elapsed_inc;
  logic                    is_tick, in_base, in_desc, in_press, in_retr, in_done, busy_phase;
  logic                    start_ok, base_pass, base_fail, desc_contact, desc_limit;
  logic                    press_stop, retr_done, done_rep;

  assign laser_s    = $signed({{(DW-LASER_BITS){1'b0}}, laser_um});
  assign target_s   = $signed({{(DW-20){1'b0}}, cfg.baseline_target_um});
  assign tol_s      = $signed({{(DW-20){1'b0}}, cfg.baseline_tolerance_um});
  assign drop_cfg_s = $signed({{(DW-20){1'b0}}, cfg.contact_drop_um});
  assign probe_s    = $signed({{(DW-LASER_BITS){1'b0}}, probe_r});
  assign claser_s   = $signed({{(DW-LASER_BITS){1'b0}}, claser_r});

  // Baseline deviation and descent drop
  assign dev         = laser_s - target_s;
  assign abs_dev     = dev[DW-1] ? -dev : dev;
  assign in_tol      = (abs_dev <= tol_s);
  assign desc_drop   = probe_s - laser_s;
  assign contact_hit = (desc_drop >= drop_cfg_s);

  // Press limits
  assign depth = $signed({z_down_um[23], z_down_um}) - $signed({cz_r[23], cz_r});
  assign f_lim = ($signed({force_mn[15], force_mn}) > $signed({2'b00, cfg.max_force_mn}));
  assign d_lim = (depth > $signed({2'b00, cfg.max_depth_um}));

  // Surface movement, saturated to 24 bits
  assign press_drop = claser_s - laser_s;
  assign surf = $signed({{(SW-DW){press_drop[DW-1]}}, press_drop})
              - $signed({{(SW-25){depth[24]}}, depth});

  always_comb begin
    if (depth[24] != depth[23]) begin
      depth_sat = depth[24] ? 24'sh800000 : 24'sh7FFFFF;
    end else begin
      depth_sat = depth[23:0];
    end
  end

  always_comb begin
    if (surf[SW-1:23] != {(SW-23){surf[SW-1]}}) begin
      surf_sat = surf[SW-1] ? 24'sh800000 : 24'sh7FFFFF;
    end else begin
      surf_sat = surf[23:0];
    end
  end

  // Saturating counters and the wrapping elapsed-tick increment
  assign stable_inc  = (stable_run_r == 8'hFF) ? stable_run_r : stable_run_r + 8'd1;
  assign confirm_inc = (confirm_r == 8'hFF) ? confirm_r : confirm_r + 8'd1;
  assign stable_val  = in_tol ? stable_inc : 8'd0;
  assign elapsed_inc = elapsed_r + 16'd1;

  // Phase decode
  assign is_tick  = (kind == pcs_pkg::KIND_TICK);
  assign in_base  = (phase_r == pcs_pkg::PH_BASE);
  assign in_desc  = (phase_r == pcs_pkg::PH_DESC);
  assign in_press = (phase_r == pcs_pkg::PH_PRESS);
  assign in_retr  = (phase_r == pcs_pkg::PH_RETR);
  assign in_done  = (phase_r == pcs_pkg::PH_DONE);
  assign busy_phase = in_base | in_desc | in_press | in_retr | in_done;

  // Transition conditions
  assign start_ok     = !is_tick && !busy_phase && !other_busy && laser_ready &&
                        (down_travel_steps != 24'd0);
  assign base_pass    = is_tick && in_base && (stable_val >= cfg.baseline_stable_count);
  assign base_fail    = is_tick && in_base && !base_pass &&
                        (elapsed_inc >= cfg.baseline_timeout_ticks);
  assign desc_contact = is_tick && in_desc && contact_hit &&
                        (confirm_inc >= cfg.contact_confirm_count);
  assign desc_limit   = is_tick && in_desc && !desc_contact && motor_idle;
  assign press_stop   = is_tick && in_press && (f_lim || d_lim || motor_idle);
  assign retr_done    = is_tick && in_retr && !homing_active && motor_idle;
  assign done_rep     = is_tick && in_done && motor_idle;

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (start_ok) begin
      phase_nxt = pcs_pkg::PH_BASE;
    end else if (base_pass) begin
      phase_nxt = pcs_pkg::PH_DESC;
    end else if (base_fail || done_rep) begin
      phase_nxt = pcs_pkg::PH_IDLE;
    end else if (desc_contact) begin
      phase_nxt = pcs_pkg::PH_PRESS;
    end else if (desc_limit || press_stop) begin
      phase_nxt = pcs_pkg::PH_RETR;
    end else if (retr_done) begin
      phase_nxt = pcs_pkg::PH_DONE;
    end
  end

  // Result of this step
  always_comb begin
    res = '0;
    res.phase     = phase_nxt;
    res.event_res = pcs_pkg::EV_NONE;
    res.motor_cmd = pcs_pkg::CMD_NONE;
    if (!is_tick) begin
      if (busy_phase) begin
        res.event_res = pcs_pkg::EV_ACTIVE;
      end else if (other_busy) begin
        res.event_res = pcs_pkg::EV_OTHER_BUSY;
      end else if (!laser_ready) begin
        res.event_res = pcs_pkg::EV_LASER_NRDY;
      end else if (down_travel_steps == 24'd0) begin
        res.event_res = pcs_pkg::EV_NO_TRAVEL;
      end
    end else if (base_pass) begin
      res.event_res  = pcs_pkg::EV_DESC_START;
      res.motor_cmd  = pcs_pkg::CMD_DOWN;
      res.move_steps = pending_r;
    end else if (base_fail) begin
      res.event_res = pcs_pkg::EV_BASE_FAIL;
    end else if (desc_contact) begin
      res.event_res = pcs_pkg::EV_CONTACT;
    end else if (desc_limit) begin
      res.event_res = pcs_pkg::EV_DESC_LIMIT;
      res.motor_cmd = pcs_pkg::CMD_RETRACT;
    end else if (press_stop) begin
      res.motor_cmd        = pcs_pkg::CMD_RETRACT;
      res.depth_um         = depth_sat;
      res.surface_moved_um = surf_sat;
      res.succeeded        = f_lim || d_lim;
      if (f_lim) begin
        res.event_res = pcs_pkg::EV_FORCE_LIMIT;
      end else if (d_lim) begin
        res.event_res = pcs_pkg::EV_DEPTH_LIMIT;
      end else begin
        res.event_res = pcs_pkg::EV_TRAVEL_LIMIT;
      end
    end else if (retr_done) begin
      res.event_res = pcs_pkg::EV_RETRACTED;
    end else if (done_rep) begin
      res.succeeded = succ_r;
      res.depth_um  = fdepth_r;
      res.event_res = succ_r ? pcs_pkg::EV_DONE_OK : pcs_pkg::EV_DONE_FAIL;
    end
  end

  // Data state updates
  always_comb begin
    stable_run_nxt = stable_run_r;
    elapsed_nxt    = elapsed_r;
    pending_nxt    = pending_r;
    probe_nxt      = probe_r;
    confirm_nxt    = confirm_r;
    claser_nxt     = claser_r;
    cz_nxt         = cz_r;
    fdepth_nxt     = fdepth_r;
    succ_nxt       = succ_r;
    if (start_ok || base_fail || done_rep) begin
      stable_run_nxt = 8'd0;
      elapsed_nxt    = 16'd0;
      pending_nxt    = start_ok ? down_travel_steps : 24'd0;
      probe_nxt      = '0;
      confirm_nxt    = 8'd0;
      claser_nxt     = '0;
      cz_nxt         = 24'd0;
      fdepth_nxt     = 24'd0;
      succ_nxt       = 1'b0;
    end else if (is_tick && in_base) begin
      elapsed_nxt    = elapsed_inc;
      stable_run_nxt = stable_val;
      if (base_pass) begin
        probe_nxt   = laser_um;
        confirm_nxt = 8'd0;
      end
    end else if (is_tick && in_desc) begin
      confirm_nxt = contact_hit ? confirm_inc : 8'd0;
      if (desc_contact) begin
        claser_nxt = laser_um;
        cz_nxt     = z_down_um;
      end
      if (desc_limit) begin
        succ_nxt   = 1'b0;
        fdepth_nxt = 24'd0;
      end
    end else if (press_stop) begin
      fdepth_nxt = depth_sat;
      succ_nxt   = f_lim || d_lim;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= pcs_pkg::PH_IDLE;
      stable_run_r <= 8'd0;
      elapsed_r    <= 16'd0;
      pending_r    <= 24'd0;
      probe_r      <= '0;
      confirm_r    <= 8'd0;
      claser_r     <= '0;
      cz_r         <= 24'd0;
      fdepth_r     <= 24'd0;
      succ_r       <= 1'b0;
    end else if (step_en) begin
      phase_r      <= phase_nxt;
      stable_run_r <= stable_run_nxt;
      elapsed_r    <= elapsed_nxt;
      pending_r    <= pending_nxt;
      probe_r      <= probe_nxt;
      confirm_r    <= confirm_nxt;
      claser_r     <= claser_nxt;
      cz_r         <= cz_nxt;
      fdepth_r     <= fdepth_nxt;
      succ_r       <= succ_nxt;
    end
  end

endmodule

// ----- design/press_contact_sequencer.sv -----
// ----------------------------------------------------------------------------
// press_contact_sequencer
// Press stroke sequencer: start checks, laser baseline, descent with contact
// confirmation, pressing to force/depth/travel limit, retract and done.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------
//  in      | in_valid / in_ready  | kind, status bits, travel, laser, force, z
//  out     | out_valid / out_ready| phase, event, motor cmd, steps, depth, surf
//  cfg     | cfg_we               | cfg_index, cfg_wdata (no read-back)
//
//  One result per input transfer; the input register captures the item and
//  the result register then loads its result from the step logic.
//  One item per cycle while out_ready is high: the input register feeds the
//  step logic, and stroke state and result register load in the same cycle.
//  A stalled result holds; the input register still takes one more item.
//  Reset (rst_n low, synchronous) restores default configuration and idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module press_contact_sequencer #(
  parameter int unsigned LASER_BITS = 20
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_kind,
  input  logic                              in_other_busy,
  input  logic                              in_laser_ready,
  input  logic [23:0]                       in_down_travel_steps,
  input  logic [LASER_BITS-1:0]             in_laser_um,
  input  logic signed [15:0]                in_force_mn,
  input  logic signed [23:0]                in_z_down_um,
  input  logic                              in_motor_idle,
  input  logic                              in_homing_active,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [2:0]                        out_phase,
  output logic [3:0]                        out_event_res,
  output logic [1:0]                        out_motor_cmd,
  output logic [23:0]                       out_move_steps,
  output logic signed [23:0]                out_depth_um,
  output logic signed [23:0]                out_surface_moved_um,
  output logic                              out_succeeded,
  // configuration
  input  logic                              cfg_we,
  input  logic [pcs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pcs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  pcs_pkg::cfg_t  cfg;
  pcs_pkg::res_t  res;
  pcs_pkg::res_t  res_r;

  // Input register
  logic                    s1_valid_r, s1_valid_nxt;
  logic                    s1_kind_r, s1_busy_r, s1_lrdy_r, s1_midle_r, s1_homing_r;
  logic [23:0]             s1_travel_r;
  logic [LASER_BITS-1:0]   s1_laser_r;
  logic signed [15:0]      s1_force_r;
  logic signed [23:0]      s1_z_r;

  logic out_valid_r, out_valid_nxt;
  logic out_free, step_en, in_xfer;

  assign out_free = !out_valid_r || out_ready;
  assign step_en  = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;
  assign in_xfer  = in_valid && in_ready;

  // Valid flags
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (step_en) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (step_en) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input payload capture
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_kind_r   <= in_kind;
      s1_busy_r   <= in_other_busy;
      s1_lrdy_r   <= in_laser_ready;
      s1_travel_r <= in_down_travel_steps;
      s1_laser_r  <= in_laser_um;
      s1_force_r  <= in_force_mn;
      s1_z_r      <= in_z_down_um;
      s1_midle_r  <= in_motor_idle;
      s1_homing_r <= in_homing_active;
    end
  end

  pcs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pcs_core #(
    .LASER_BITS (LASER_BITS)
  ) u_core (
    .clk               (clk),
    .rst_n             (rst_n),
    .step_en           (step_en),
    .cfg               (cfg),
    .kind              (s1_kind_r),
    .other_busy        (s1_busy_r),
    .laser_ready       (s1_lrdy_r),
    .down_travel_steps (s1_travel_r),
    .laser_um          (s1_laser_r),
    .force_mn          (s1_force_r),
    .z_down_um         (s1_z_r),
    .motor_idle        (s1_midle_r),
    .homing_active     (s1_homing_r),
    .res               (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (step_en) begin
      res_r <= res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_phase            = res_r.phase;
  assign out_event_res        = res_r.event_res;
  assign out_motor_cmd        = res_r.motor_cmd;
  assign out_move_steps       = res_r.move_steps;
  assign out_depth_um         = res_r.depth_um;
  assign out_surface_moved_um = res_r.surface_moved_um;
  assign out_succeeded        = res_r.succeeded;

  // Checks
  `include "press_contact_sequencer_assert.svh"

  `PCS_ASSERT_IMP(a_down_only_on_descent, out_valid_r, ((out_motor_cmd == pcs_pkg::CMD_DOWN) == (out_event_res == pcs_pkg::EV_DESC_START)), "move down without descent start")
  `PCS_ASSERT_IMP(a_success_events, out_valid_r && out_succeeded, (out_event_res == pcs_pkg::EV_FORCE_LIMIT) || (out_event_res == pcs_pkg::EV_DEPTH_LIMIT) || (out_event_res == pcs_pkg::EV_DONE_OK), "success flag on wrong event")
  `PCS_ASSERT_IMP(a_retract_to_done, out_valid_r && (out_event_res == pcs_pkg::EV_RETRACTED), out_phase == pcs_pkg::PH_DONE, "retracted event without done phase")
  `PCS_ASSERT_NXT(a_step_loads_result, step_en, out_valid_r, "stepped item left no result")

endmodule
